@@ rtl/lpep_pkg.sv @@
// Shared constants and types for the layer prefetch / eviction policy unit.
// Used by the controller, the datapath and the top level; no dependencies.
package lpep_pkg;
	localparam int DEF_MAX_LAYERS = 128;
	localparam int DEF_TIME_BITS  = 32;

	localparam logic [1:0] REG_LAYER_COUNT = 2'd0;
	localparam logic [1:0] REG_PF_DIST     = 2'd1;
	localparam logic [1:0] REG_COLD_TICKS  = 2'd2;
	localparam logic [1:0] REG_WS_TARGET   = 2'd3;

	localparam logic [1:0] TEMP_COLD = 2'd0;
	localparam logic [1:0] TEMP_WARM = 2'd1;
	localparam logic [1:0] TEMP_HOT  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;      // latch request and do the first touch
		logic scan_clr;   // reset the scan index and scan bookkeeping
		logic age_step;   // age one entry
		logic vic_step;   // examine one entry as an eviction candidate
		logic evict;      // evict the chosen victim
		logic count_step; // count one resident entry
		logic prefetch;   // compute and issue the prefetch
	} lpep_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;      // completion or bad index: no aging or eviction scans
		logic scan_last; // scan index at last live entry
		logic need_evict;
		logic found;
		logic pf_busy;   // prefetch target still being reduced modulo the layer count
	} lpep_sts_t;
endpackage

@@ rtl/lpep_ctrl.sv @@
// Controller state machine for the layer prefetch / eviction policy unit.
// Depends on lpep_pkg; drives the datapath through lpep_cmd_t.
module lpep_ctrl
	import lpep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  lpep_sts_t sts,
	output lpep_cmd_t cmd
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_AGE   = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_VIC   = 4'd3;
	localparam logic [3:0] ST_EVICT = 4'd4;
	localparam logic [3:0] ST_PF    = 4'd5;
	localparam logic [3:0] ST_CNT   = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;
	localparam logic [3:0] ST_VWAIT = 4'd8;

	logic [3:0] state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_AGE;
				end
			end
			ST_AGE: begin
				if (sts.skip) begin
					state_d = ST_CNT;
				end else begin
					cmd.age_step = 1'b1;
					if (sts.scan_last) begin
						cmd.scan_clr = 1'b1;
						state_d = ST_CHK;
					end
				end
			end
			ST_CHK: begin
				cmd.scan_clr = 1'b1;
				state_d = sts.need_evict ? ST_VIC : ST_PF;
			end
			ST_VIC: begin
				cmd.vic_step = 1'b1;
				if (sts.scan_last) state_d = ST_VWAIT;
			end
			// The last candidate's timestamp read lands here.
			ST_VWAIT: begin
				state_d = ST_EVICT;
			end
			ST_EVICT: begin
				if (sts.found) begin
					cmd.evict = 1'b1;
					state_d = ST_CHK;
				end else begin
					state_d = ST_PF;
				end
			end
			ST_PF: begin
				if (!sts.pf_busy) begin
					cmd.prefetch = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				cmd.count_step = 1'b1;
				if (sts.scan_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ rtl/lpep_dp.sv @@
// Datapath for the layer prefetch / eviction policy unit: per-layer state,
// scan index, victim search and result registers. Depends on lpep_pkg.
module lpep_dp
	import lpep_pkg::*;
#(
	parameter int MAX_LAYERS = DEF_MAX_LAYERS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpep_cmd_t            cmd,
	output lpep_sts_t            sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_command,
	input  logic [6:0]           in_layer,
	input  logic [TIME_BITS-1:0] in_now,
	output logic [7:0]           evicted_count,
	output logic                 prefetch_issued,
	output logic [6:0]           prefetch_target,
	output logic [7:0]           resident_count,
	output logic [7:0]           working_set_size,
	output logic                 index_error
);
	localparam int IW = $clog2(MAX_LAYERS);
	localparam int CW = IW + 1;
	localparam int RW = CW + 8;

	logic [7:0]           layer_count_q;
	logic [6:0]           pf_dist_q;
	logic [31:0]          cold_ticks_q;
	logic [7:0]           ws_target_q;

	logic [MAX_LAYERS-1:0] res_q, pfb_q;
	logic [1:0]            temp_q [MAX_LAYERS];
	logic [TIME_BITS-1:0]  lut_q  [MAX_LAYERS];

	logic [7:0]           ws_q;
	logic [IW-1:0]        pend_q;
	logic                 pend_v_q;
	logic                 skip_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IW-1:0]        scan_q;
	logic                 found_q;
	logic [IW-1:0]        vic_q;
	logic [TIME_BITS-1:0] best_q;
	logic [7:0]           evc_q, rc_q;
	logic                 iss_q;
	logic [6:0]           tgt_q;

	// Age and victim steps act in the cycle after their scan index, once the
	// registered timestamp read is back.
	logic                 age_s1, vic_s1;
	logic [IW-1:0]        scan_s1;
	logic [TIME_BITS-1:0] lut_rd_s1;

	// Restoring remainder for the prefetch target, one step per cycle.
	logic [RW-1:0]        pf_rem_q;
	logic [3:0]           pf_cnt_q;
	logic [RW-1:0]        pf_sub;

	// Live layer count, clipped to the table size.
	logic [CW-1:0] lc;
	logic [CW-1:0] last_idx;
	always_comb begin
		if (32'(layer_count_q) > 32'(MAX_LAYERS))
			lc = CW'(MAX_LAYERS);
		else
			lc = CW'(layer_count_q);
		last_idx = lc - CW'(1);
	end

	logic [TIME_BITS-1:0] age;
	logic [TIME_BITS-1:0] cold_ext;
	logic                 in_bad;
	assign age      = now_q - lut_rd_s1;
	assign cold_ext = TIME_BITS >= 32 ? TIME_BITS'(cold_ticks_q) : TIME_BITS'(cold_ticks_q);
	assign in_bad   = (CW'(in_layer) >= lc) || (32'(in_layer) >= 32'(MAX_LAYERS));

	logic cold_over;
	always_comb begin
		if (TIME_BITS < 32 && cold_ticks_q > 32'((64'd1 << TIME_BITS) - 64'd1)) cold_over = 1'b0;
		else cold_over = age > cold_ext;
	end

	// The sum of index and distance stays below 256, so eight shifted
	// compare-and-subtract steps leave it reduced modulo the live count.
	assign pf_sub = RW'(lc) << (pf_cnt_q - 4'd1);

	logic [IW-1:0] nx;
	assign nx = IW'(pf_rem_q);

	assign sts.skip       = skip_q;
	assign sts.scan_last  = (lc == '0) || ({1'b0, scan_q} >= last_idx);
	assign sts.need_evict = ws_q > ws_target_q;
	assign sts.found      = found_q;
	assign sts.pf_busy    = (pf_cnt_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 8'd128;
			pf_dist_q <= 7'd2;
			cold_ticks_q <= 32'd500;
			ws_target_q <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYER_COUNT: layer_count_q <= cfg_data[7:0];
				REG_PF_DIST:     pf_dist_q <= cfg_data[6:0];
				REG_COLD_TICKS:  cold_ticks_q <= cfg_data;
				REG_WS_TARGET:   ws_target_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Last-use timestamps: written on a touch, read one entry per cycle.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (in_command) begin
				if (pend_v_q && !res_q[pend_q]) lut_q[pend_q] <= in_now;
			end else if (!in_bad) begin
				lut_q[IW'(in_layer)] <= in_now;
			end
		end
		lut_rd_s1 <= lut_q[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_rem_q <= '0;
			pf_cnt_q <= 4'd0;
		end else if (cmd.start) begin
			pf_rem_q <= RW'(in_layer) + RW'(pf_dist_q);
			pf_cnt_q <= 4'd8;
		end else if (pf_cnt_q != 4'd0) begin
			if (pf_rem_q >= pf_sub) pf_rem_q <= pf_rem_q - pf_sub;
			pf_cnt_q <= pf_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			pfb_q <= '0;
			for (int i = 0; i < MAX_LAYERS; i++) temp_q[i] <= TEMP_COLD;
			ws_q <= '0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
			skip_q <= 1'b0;
			now_q <= '0;
			found_q <= 1'b0;
			vic_q <= '0;
			best_q <= '0;
			evc_q <= '0;
			rc_q <= '0;
			iss_q <= 1'b0;
			tgt_q <= '0;
			index_error <= 1'b0;
			scan_q <= '0;
			age_s1 <= 1'b0;
			vic_s1 <= 1'b0;
			scan_s1 <= '0;
		end else begin
			age_s1 <= cmd.age_step;
			vic_s1 <= cmd.vic_step;
			scan_s1 <= scan_q;
			if (cmd.start) begin
				now_q <= in_now;
				evc_q <= '0;
				iss_q <= 1'b0;
				tgt_q <= '0;
				index_error <= !in_command && in_bad;
				skip_q <= in_command || in_bad;
				if (in_command) begin
					if (pend_v_q && !res_q[pend_q]) begin
						res_q[pend_q] <= 1'b1;
						pfb_q[pend_q] <= 1'b0;
						temp_q[pend_q] <= TEMP_HOT;
						if (ws_q != 8'hFF) ws_q <= ws_q + 8'd1;
					end
					pend_v_q <= 1'b0;
				end else if (!in_bad) begin
					if (!res_q[IW'(in_layer)]) begin
						res_q[IW'(in_layer)] <= 1'b1;
						pfb_q[IW'(in_layer)] <= 1'b0;
						temp_q[IW'(in_layer)] <= TEMP_HOT;
						if (ws_q != 8'hFF) ws_q <= ws_q + 8'd1;
					end
				end
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
				found_q <= 1'b0;
				rc_q <= '0;
			end else if (cmd.age_step || cmd.vic_step || cmd.count_step) begin
				scan_q <= scan_q + IW'(1);
			end
			if (age_s1 && res_q[scan_s1] && cold_over)
				temp_q[scan_s1] <= TEMP_WARM;
			if (vic_s1 && res_q[scan_s1] && temp_q[scan_s1] != TEMP_HOT
				&& (!found_q || age > best_q)) begin
				found_q <= 1'b1;
				best_q <= age;
				vic_q <= scan_s1;
			end
			if (cmd.evict) begin
				res_q[vic_q] <= 1'b0;
				temp_q[vic_q] <= TEMP_COLD;
				ws_q <= ws_q - 8'd1;
				evc_q <= evc_q + 8'd1;
			end
			if (cmd.count_step && res_q[scan_q] && ({1'b0, scan_q} < lc))
				rc_q <= rc_q + 8'd1;
			if (cmd.prefetch && !res_q[nx] && !pfb_q[nx]) begin
				pfb_q[nx] <= 1'b1;
				pend_q <= nx;
				pend_v_q <= 1'b1;
				iss_q <= 1'b1;
				tgt_q <= 7'(nx);
			end
		end
	end

	assign evicted_count    = evc_q;
	assign prefetch_issued  = iss_q;
	assign prefetch_target  = tgt_q;
	assign resident_count   = rc_q;
	assign working_set_size = ws_q;
endmodule

@@ rtl/layer_prefetch_evict_policy_unit.sv @@
// Top level of the layer prefetch / eviction policy unit.
// Depends on lpep_pkg, lpep_ctrl and lpep_dp.
//
// One request is worked at a time; L below is the live layer count (the
// layer count register clipped to MAX_LAYERS). A layer-start request is
// accepted, ages L entries, passes a check, and for each eviction runs a
// full victim scan, waits for the last timestamp read, evicts and checks
// again; it then makes the prefetch decision, recounts residency over L
// entries and hands over the result. A scan that finds no candidate goes on
// to the prefetch decision. One shared scan counter over the live layers
// serves the aging, victim and recount scans. The prefetch target is reduced
// modulo L by shifted compare-and-subtract steps started at acceptance,
// which can hold the prefetch decision when L is very small. A completion
// or bad-index request skips aging, eviction and the prefetch decision.
// Timestamps sit in a memory read one entry per cycle through a register.
// The result is held in registers until taken; configuration must be
// written only while idle, and the block itself does not enforce this.
module layer_prefetch_evict_policy_unit
	import lpep_pkg::*;
#(
	parameter int MAX_LAYERS = DEF_MAX_LAYERS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [6:0]           layer_index,
	input  logic [TIME_BITS-1:0] now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           evicted_count,
	output logic                 prefetch_issued,
	output logic [6:0]           prefetch_target,
	output logic [7:0]           resident_count,
	output logic [7:0]           working_set_size,
	output logic                 index_error
);
	lpep_cmd_t cmd;
	lpep_sts_t sts;

	lpep_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	lpep_dp #(.MAX_LAYERS(MAX_LAYERS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_command(command), .in_layer(layer_index), .in_now(now),
		.evicted_count(evicted_count), .prefetch_issued(prefetch_issued),
		.prefetch_target(prefetch_target), .resident_count(resident_count),
		.working_set_size(working_set_size), .index_error(index_error)
	);
endmodule

@@ rtl/lpep_checker.sv @@
// Port-level checker for the layer prefetch / eviction policy unit.
// Depends on lpep_pkg; bound to the top level below.
module lpep_checker
	import lpep_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       prefetch_issued,
	input logic [6:0] prefetch_target,
	input logic [7:0] evicted_count,
	input logic       index_error
);
	// One request at a time: no new request while a result waits.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// A taken request keeps the input closed on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input open right after a request");
	// A held result's evicted count stays still until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(evicted_count))
		else $error("result changed while stalled");
	// An index error never evicts or prefetches.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> evicted_count == 8'd0 && !prefetch_issued)
		else $error("bad index had side effects");
	// No target without a prefetch.
	a_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !prefetch_issued |-> prefetch_target == 7'd0)
		else $error("target without prefetch");
endmodule

bind layer_prefetch_evict_policy_unit lpep_checker u_lpep_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .prefetch_issued(prefetch_issued),
	.prefetch_target(prefetch_target), .evicted_count(evicted_count),
	.index_error(index_error)
);
